@@ src/tdq_pkg.sv @@
// Package with the shared types and constants of the target-decoy q-value engine.
package tdq_pkg;

	localparam int unsigned ONE_Q16 = 65536;
	localparam int unsigned TGT_MAX = 1024;
	localparam int unsigned DEC_MAX = 67108864;
	localparam int unsigned TGT_W   = 11;
	localparam int unsigned DEC_W   = 27;
	localparam int unsigned Q_W     = 17;
	localparam int unsigned NOTCH_W = 3;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FRAC,
		S_ADD,
		S_DIV_Q,
		S_DIV_QN,
		S_PUSH_WR,
		S_POP_RD,
		S_POP_WAIT,
		S_POP_MIN,
		S_OUT
	} state_t;

endpackage

@@ src/target_decoy_qvalue_engine.sv @@
// Top level of the target-decoy q-value engine: counters, stack and serial divider.
//
// Usage: the input channel (in_valid/in_ready) carries one beat per match or pop.
// A push (opcode 0) counts the match as a target or as a Q16 decoy fraction,
// overall and under its notch, then returns the raw q-values and stacks them.
// A pop (opcode 1) returns stacked entries in reverse order with a running
// minimum applied; the pop that empties the stack clears all counters.
// One result beat leaves on out_valid/out_ready for every input beat.
// The configuration channel (cfg_valid/cfg_ready) writes num_notches; it is
// accepted only while no item is in flight and no result waits.
// Timing: the restoring divider works one quotient bit per cycle over DIV_W = 28
// bits, and a division is skipped when its divisor is zero or the match is not a decoy. A
// push runs up to three of them (decoy fraction, overall q, notch q) before its result
// is registered. A pop reads the stack in S_POP_RD, waits in S_POP_WAIT for the
// registered read and registers its result in S_POP_MIN; an error goes out via S_OUT.
// The next item is taken in the cycle after a result is registered, even while that
// result still waits; if the receiver stalls, a second result holds the engine in its
// last state until the output register is free. Reset clears counters, the stack
// pointer and thresholds at once; the stack contents are left undefined.
module target_decoy_qvalue_engine
	import tdq_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 1024,
	parameter int unsigned MAX_NOTCHES = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic                is_decoy,
	input  logic [3:0]          decoy_hits,
	input  logic [3:0]          total_hits,
	input  logic                has_notch,
	input  logic [2:0]          notch_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                is_final,
	output logic                group_done,
	output logic [TGT_W-1:0]    target_count,
	output logic [DEC_W-1:0]    decoy_sum,
	output logic [Q_W-1:0]      q_value,
	output logic [TGT_W-1:0]    notch_target_count,
	output logic [DEC_W-1:0]    notch_decoy_sum,
	output logic [Q_W-1:0]      notch_q_value,
	output logic [NOTCH_W-1:0]  notch_index
);

	localparam int unsigned NSLOTS = MAX_NOTCHES + 1;
	localparam int unsigned SL_W   = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
	localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AD_W   = $clog2(STACK_DEPTH);
	localparam int unsigned E_W    = 2 * Q_W + NOTCH_W;
	localparam int unsigned DIV_W  = DEC_W + 1;
	localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
	localparam logic [NOTCH_W-1:0] MAXN = NOTCH_W'(MAX_NOTCHES);

	state_t state_q, state_d;

	logic [2:0]             num_notches_q;
	logic [TGT_W-1:0]       tot_tgt_q;
	logic [DEC_W-1:0]       tot_dec_q;
	logic [TGT_W-1:0]       n_tgt_q [NSLOTS];
	logic [DEC_W-1:0]       n_dec_q [NSLOTS];
	logic [Q_W-1:0]         thr_q;
	logic [Q_W-1:0]         n_thr_q [NSLOTS];
	logic [SP_W-1:0]        sp_q;
	logic [SP_W-1:0]        sp_prev;
	logic [E_W-1:0]         stack_mem [STACK_DEPTH];
	logic [E_W-1:0]         rd_data_q;

	// Latched item fields.
	logic                   op_q, dec_q;
	logic [3:0]             dh_q, th_q;
	logic [NOTCH_W-1:0]     notch_q;

	// Serial divider: one quotient bit per cycle.
	logic [DIV_W-1:0]       dvd_q, quo_q;
	logic [DIV_W-1:0]       rem_q;
	logic [TGT_W-1:0]       dvs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   div_busy_q;
	logic [DIV_W:0]         rem_sh;
	logic                   div_start;
	logic [DIV_W-1:0]       start_dvd;
	logic [TGT_W-1:0]       start_dvs;

	logic [Q_W-1:0]         frac_q, q_q, qn_q;

	// Output register.
	logic                   ov_q;
	status_t                st_q;
	logic                   fin_q, gd_q;
	logic [TGT_W-1:0]       o_tc_q, o_ntc_q;
	logic [DEC_W-1:0]       o_ds_q, o_nds_q;
	logic [Q_W-1:0]         o_q_q, o_nq_q;
	logic [NOTCH_W-1:0]     o_ni_q;

	logic                   accept;
	logic                   out_free, load_out;
	logic [NOTCH_W-1:0]     nn_eff, notch_in;
	logic [SL_W-1:0]        slot;

	assign cfg_ready = (state_q == S_IDLE) && !ov_q;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot      = SL_W'(notch_q);
	assign sp_prev   = sp_q - 1'b1;

	// The output register can take a new beat when it is empty or being emptied.
	assign out_free = !ov_q || out_ready;
	assign load_out = out_free &&
		(state_q == S_PUSH_WR || state_q == S_POP_MIN || state_q == S_OUT);

	// Effective notch of the incoming beat.
	always_comb begin
		nn_eff   = (num_notches_q > MAXN) ? MAXN : num_notches_q;
		notch_in = has_notch ? ((notch_value > nn_eff) ? nn_eff : notch_value) : nn_eff;
	end

	// Saturating q cap of the quotient.
	function automatic logic [Q_W-1:0] cap_q(input logic [DIV_W-1:0] v);
		logic [Q_W-1:0] r;
		r = (v > DIV_W'(ONE_Q16)) ? Q_W'(ONE_Q16) : v[Q_W-1:0];
		return r;
	endfunction

	// Divider start operands per state.
	always_comb begin
		start_dvd = '0;
		start_dvs = '0;
		div_start = 1'b0;
		unique case (state_q)
			S_FRAC: begin
				div_start = !div_busy_q && dec_q && (th_q != 4'd0);
				start_dvd = DIV_W'({((dh_q > th_q) ? th_q : dh_q), 16'd0});
				start_dvs = TGT_W'(th_q);
			end
			S_ADD: begin
				div_start = 1'b0;
			end
			S_DIV_Q: begin
				div_start = !div_busy_q && (tot_tgt_q != '0);
				start_dvd = DIV_W'(tot_dec_q);
				start_dvs = tot_tgt_q;
			end
			S_DIV_QN: begin
				div_start = !div_busy_q && (n_tgt_q[slot] != '0);
				start_dvd = DIV_W'(n_dec_q[slot]);
				start_dvs = n_tgt_q[slot];
			end
			default: div_start = 1'b0;
		endcase
	end

	assign rem_sh = {rem_q, dvd_q[DIV_W-1]};

	// Divider datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			cnt_q      <= '0;
		end else if (div_start && (state_d == state_q)) begin
			div_busy_q <= 1'b1;
			cnt_q      <= CNT_W'(DIV_W);
		end else if (div_busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_start && !div_busy_q) begin
			dvd_q <= start_dvd;
			dvs_q <= start_dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (div_busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			if (rem_sh >= (DIV_W+1)'(dvs_q)) begin
				rem_q <= DIV_W'(rem_sh - (DIV_W+1)'(dvs_q));
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	logic div_done;
	assign div_done = div_busy_q && (cnt_q == CNT_W'(1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode) begin
						state_d = (sp_q == '0) ? S_OUT : S_POP_RD;
					end else begin
						state_d = (sp_q >= SP_W'(STACK_DEPTH)) ? S_OUT : S_FRAC;
					end
				end
			end
			S_FRAC: begin
				if (!dec_q || th_q == 4'd0) begin
					state_d = S_ADD;
				end else if (div_done) begin
					state_d = S_ADD;
				end
			end
			S_ADD:    state_d = S_DIV_Q;
			S_DIV_Q: begin
				if (tot_tgt_q == '0 || div_done) begin
					state_d = S_DIV_QN;
				end
			end
			S_DIV_QN: begin
				if (n_tgt_q[slot] == '0 || div_done) begin
					state_d = S_PUSH_WR;
				end
			end
			S_PUSH_WR: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_POP_RD:   state_d = S_POP_WAIT;
			S_POP_WAIT: state_d = S_POP_MIN;
			S_POP_MIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= opcode;
			dec_q   <= is_decoy;
			dh_q    <= decoy_hits;
			th_q    <= total_hits;
			notch_q <= notch_in;
		end
	end

	// Stack memory; a pop reads the entry just below the stack pointer.
	always_ff @(posedge clk) begin
		if (state_q == S_PUSH_WR && out_free) begin
			stack_mem[sp_q[AD_W-1:0]] <= {notch_q, qn_q, q_q};
		end
		if (state_q == S_POP_RD) begin
			rd_data_q <= stack_mem[sp_prev[AD_W-1:0]];
		end
	end

	// Counters, thresholds, stack pointer and output register.
	logic [NOTCH_W-1:0] rd_notch;
	logic [SL_W-1:0]    rd_slot;
	logic [Q_W-1:0]     rd_q, rd_qn;
	logic [DEC_W:0]     dsum, ndsum;
	always_comb begin
		rd_q     = rd_data_q[Q_W-1:0];
		rd_qn    = rd_data_q[2*Q_W-1:Q_W];
		rd_notch = rd_data_q[E_W-1:2*Q_W];
		if (rd_notch > MAXN) begin
			rd_notch = MAXN;
		end
		rd_slot = SL_W'(rd_notch);
		dsum    = (DEC_W+1)'(tot_dec_q) + (DEC_W+1)'(frac_q);
		ndsum   = (DEC_W+1)'(n_dec_q[slot]) + (DEC_W+1)'(frac_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_notches_q <= '0;
			tot_tgt_q     <= '0;
			tot_dec_q     <= '0;
			thr_q         <= Q_W'(ONE_Q16);
			sp_q          <= '0;
			ov_q          <= 1'b0;
			for (int i = 0; i < NSLOTS; i++) begin
				n_tgt_q[i] <= '0;
				n_dec_q[i] <= '0;
				n_thr_q[i] <= Q_W'(ONE_Q16);
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				num_notches_q <= cfg_data;
			end
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_ADD: begin
					if (dec_q) begin
						tot_dec_q <= (dsum > (DEC_W+1)'(DEC_MAX)) ?
							DEC_W'(DEC_MAX) : dsum[DEC_W-1:0];
						n_dec_q[slot] <= (ndsum > (DEC_W+1)'(DEC_MAX)) ?
							DEC_W'(DEC_MAX) : ndsum[DEC_W-1:0];
					end else begin
						if (tot_tgt_q < TGT_W'(TGT_MAX)) begin
							tot_tgt_q <= tot_tgt_q + 1'b1;
						end
						if (n_tgt_q[slot] < TGT_W'(TGT_MAX)) begin
							n_tgt_q[slot] <= n_tgt_q[slot] + 1'b1;
						end
					end
				end
				S_PUSH_WR: begin
					if (out_free) begin
						sp_q <= sp_q + 1'b1;
					end
				end
				S_POP_RD: begin
					sp_q <= sp_q - 1'b1;
				end
				S_POP_MIN: begin
					if (out_free) begin
						if (sp_q == '0) begin
							tot_tgt_q <= '0;
							tot_dec_q <= '0;
							thr_q     <= Q_W'(ONE_Q16);
							for (int i = 0; i < NSLOTS; i++) begin
								n_tgt_q[i] <= '0;
								n_dec_q[i] <= '0;
								n_thr_q[i] <= Q_W'(ONE_Q16);
							end
						end else begin
							if (rd_q <= thr_q) begin
								thr_q <= rd_q;
							end
							if (rd_qn <= n_thr_q[rd_slot]) begin
								n_thr_q[rd_slot] <= rd_qn;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Divider results and output payload.
	always_ff @(posedge clk) begin
		if (state_q == S_FRAC) begin
			if (!dec_q) begin
				frac_q <= '0;
			end else if (th_q == 4'd0 || dh_q >= th_q) begin
				frac_q <= Q_W'(ONE_Q16);
			end else if (div_done) begin
				frac_q <= cap_q({quo_q[DIV_W-2:0], (rem_sh >= (DIV_W+1)'(dvs_q))});
			end
		end
		if (state_q == S_DIV_Q) begin
			if (tot_tgt_q == '0) begin
				q_q <= Q_W'(ONE_Q16);
			end else if (div_done) begin
				q_q <= cap_q({quo_q[DIV_W-2:0], (rem_sh >= (DIV_W+1)'(dvs_q))});
			end
		end
		if (state_q == S_DIV_QN) begin
			if (n_tgt_q[slot] == '0) begin
				qn_q <= Q_W'(ONE_Q16);
			end else if (div_done) begin
				qn_q <= cap_q({quo_q[DIV_W-2:0], (rem_sh >= (DIV_W+1)'(dvs_q))});
			end
		end
		if (load_out) begin
			unique case (state_q)
				S_PUSH_WR: begin
					st_q    <= ST_OK;
					fin_q   <= 1'b0;
					gd_q    <= 1'b0;
					o_tc_q  <= tot_tgt_q;
					o_ds_q  <= tot_dec_q;
					o_q_q   <= q_q;
					o_ntc_q <= n_tgt_q[slot];
					o_nds_q <= n_dec_q[slot];
					o_nq_q  <= qn_q;
					o_ni_q  <= notch_q;
				end
				S_POP_MIN: begin
					st_q    <= ST_OK;
					fin_q   <= 1'b1;
					gd_q    <= (sp_q == '0);
					o_tc_q  <= '0;
					o_ds_q  <= '0;
					o_q_q   <= (rd_q > thr_q) ? thr_q : rd_q;
					o_ntc_q <= '0;
					o_nds_q <= '0;
					o_nq_q  <= (rd_qn > n_thr_q[rd_slot]) ? n_thr_q[rd_slot] : rd_qn;
					o_ni_q  <= rd_notch;
				end
				S_OUT: begin
					st_q    <= op_q ? ST_EMPTY : ST_FULL;
					fin_q   <= 1'b0;
					gd_q    <= 1'b0;
					o_tc_q  <= '0;
					o_ds_q  <= '0;
					o_q_q   <= '0;
					o_ntc_q <= '0;
					o_nds_q <= '0;
					o_nq_q  <= '0;
					o_ni_q  <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid          = ov_q;
	assign status             = st_q;
	assign is_final           = fin_q;
	assign group_done         = gd_q;
	assign target_count       = o_tc_q;
	assign decoy_sum          = o_ds_q;
	assign q_value            = o_q_q;
	assign notch_target_count = o_ntc_q;
	assign notch_decoy_sum    = o_nds_q;
	assign notch_q_value      = o_nq_q;
	assign notch_index        = o_ni_q;

	// The stack pointer never passes the depth.
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	// The overall threshold never rises above one.
	a_thr_range: assert property (@(posedge clk) disable iff (!arst_n)
		thr_q <= Q_W'(ONE_Q16))
		else $error("threshold above one");

	// A result beat that is not taken stays valid, with its status, q-values and notch index unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> (ov_q && $stable(st_q) && $stable(o_q_q) &&
			$stable(o_nq_q) && $stable(o_ni_q)))
		else $error("result beat changed while stalled");

	// The divider only runs inside a division state.
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy_q |-> (state_q == S_FRAC || state_q == S_DIV_Q || state_q == S_DIV_QN))
		else $error("divider busy outside a division");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the target-decoy q-value engine.
module testbench;
	import tdq_pkg::*;

	typedef enum bit {OP_PUSH = 1'b0, OP_POP = 1'b1} op_e;

	// One input beat.
	typedef struct {
		op_e        op;
		bit         dec;
		bit [3:0]   dh;
		bit [3:0]   th;
		bit         has;
		bit [2:0]   nv;
	} match_t;

	// One result beat.
	typedef struct {
		logic [1:0]          status;
		logic                is_final;
		logic                group_done;
		logic [TGT_W-1:0]    tc;
		logic [DEC_W-1:0]    ds;
		logic [Q_W-1:0]      q;
		logic [TGT_W-1:0]    ntc;
		logic [DEC_W-1:0]    nds;
		logic [Q_W-1:0]      nq;
		logic [NOTCH_W-1:0]  ni;
	} qres_t;

	// A row of the directed table: either a register write or an item, with
	// an optional typed-in expectation.
	typedef struct {
		bit     is_cfg;
		int     cval;
		match_t it;
		bit     typed;
		qres_t  exp;
	} dir_row_t;

	localparam int unsigned DEPTH = 1024;
	localparam int unsigned SLOTS = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = 1'b0;
	logic is_decoy = 1'b0;
	logic [3:0] decoy_hits = '0;
	logic [3:0] total_hits = '0;
	logic has_notch = 1'b0;
	logic [2:0] notch_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic is_final;
	logic group_done;
	logic [TGT_W-1:0] target_count;
	logic [DEC_W-1:0] decoy_sum;
	logic [Q_W-1:0] q_value;
	logic [TGT_W-1:0] notch_target_count;
	logic [DEC_W-1:0] notch_decoy_sum;
	logic [Q_W-1:0] notch_q_value;
	logic [NOTCH_W-1:0] notch_index;

	target_decoy_qvalue_engine u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.is_decoy(is_decoy), .decoy_hits(decoy_hits), .total_hits(total_hits),
		.has_notch(has_notch), .notch_value(notch_value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.is_final(is_final), .group_done(group_done),
		.target_count(target_count), .decoy_sum(decoy_sum), .q_value(q_value),
		.notch_target_count(notch_target_count), .notch_decoy_sum(notch_decoy_sum),
		.notch_q_value(notch_q_value), .notch_index(notch_index)
	);

	// Shadow state of the engine.
	int unsigned notch_cfg;
	int unsigned tot_tgt, tot_dec, thr;
	int unsigned ntgt [SLOTS];
	int unsigned ndec [SLOTS];
	int unsigned nthr [SLOTS];
	int unsigned stk_q [DEPTH];
	int unsigned stk_qn [DEPTH];
	int unsigned stk_n [DEPTH];
	int unsigned depth;

	qres_t pending_results [$];
	dir_row_t dir_tab [$];
	int unsigned mismatches = 0;
	int unsigned n_sent = 0;
	bit quiet = 1'b0;
	bit calm = 1'b0;
	int unsigned n_push = 0, n_pop = 0, n_full = 0, n_empty = 0, n_groups = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Appends one row to the directed table.
	function automatic void add_row(dir_row_t row);
		dir_tab.insert(dir_tab.size(), row);
	endfunction

	function automatic void clear_counts();
		tot_tgt = 0;
		tot_dec = 0;
		thr = ONE_Q16;
		for (int i = 0; i < SLOTS; i++) begin
			ntgt[i] = 0;
			ndec[i] = 0;
			nthr[i] = ONE_Q16;
		end
	endfunction

	function automatic int unsigned q_ratio(int unsigned d, int unsigned t);
		int unsigned r;
		if (t == 0)
			return ONE_Q16;
		r = d / t;
		return (r > ONE_Q16) ? ONE_Q16 : r;
	endfunction

	function automatic int unsigned sat(int unsigned a, int unsigned b, int unsigned m);
		return (a + b > m) ? m : a + b;
	endfunction

	// Works out the result of one accepted beat and advances the shadow state.
	function automatic qres_t qval_predict(match_t it);
		qres_t r;
		int unsigned frac, dh, sel, qv, qn;
		r = '{default: '0};
		if (it.op == OP_PUSH) begin
			sel = it.has ? ((it.nv > notch_cfg) ? notch_cfg : it.nv) : notch_cfg;
			if (depth >= DEPTH) begin
				r.status = ST_FULL;
				n_full++;
				return r;
			end
			if (it.dec) begin
				if (it.th == 0) begin
					frac = ONE_Q16;
				end else begin
					dh = (it.dh > it.th) ? it.th : it.dh;
					frac = (dh * ONE_Q16) / it.th;
				end
				tot_dec = sat(tot_dec, frac, DEC_MAX);
				ndec[sel] = sat(ndec[sel], frac, DEC_MAX);
			end else begin
				tot_tgt = sat(tot_tgt, 1, TGT_MAX);
				ntgt[sel] = sat(ntgt[sel], 1, TGT_MAX);
			end
			qv = q_ratio(tot_dec, tot_tgt);
			qn = q_ratio(ndec[sel], ntgt[sel]);
			stk_q[depth] = qv;
			stk_qn[depth] = qn;
			stk_n[depth] = sel;
			depth++;
			n_push++;
			r.status = ST_OK;
			r.tc = TGT_W'(tot_tgt);
			r.ds = DEC_W'(tot_dec);
			r.q = Q_W'(qv);
			r.ntc = TGT_W'(ntgt[sel]);
			r.nds = DEC_W'(ndec[sel]);
			r.nq = Q_W'(qn);
			r.ni = NOTCH_W'(sel);
		end else begin
			if (depth == 0) begin
				r.status = ST_EMPTY;
				n_empty++;
				return r;
			end
			depth--;
			qv = stk_q[depth];
			qn = stk_qn[depth];
			sel = stk_n[depth];
			// Running minimum, overall and under the entry's notch.
			if (qv > thr)
				qv = thr;
			else
				thr = qv;
			if (qn > nthr[sel])
				qn = nthr[sel];
			else
				nthr[sel] = qn;
			n_pop++;
			r.status = ST_OK;
			r.is_final = 1'b1;
			r.q = Q_W'(qv);
			r.nq = Q_W'(qn);
			r.ni = NOTCH_W'(sel);
			if (depth == 0) begin
				clear_counts();
				r.group_done = 1'b1;
				n_groups++;
			end
		end
		return r;
	endfunction

	// Drives one beat, waits for it to be taken and records what it must yield.
	task automatic send_match(match_t it, bit typed, qres_t texp);
		qres_t r;
		int unsigned gap;
		if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= it.op;
		is_decoy <= it.dec;
		decoy_hits <= it.dh;
		total_hits <= it.th;
		has_notch <= it.has;
		notch_value <= it.nv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		r = qval_predict(it);
		pending_results.insert(pending_results.size(), typed ? texp : r);
		n_sent++;
	endtask

	// Writes num_notches once all results are back and the input is quiet.
	task automatic write_notches(int unsigned v);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v[2:0];
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		notch_cfg = v;
	endtask

	function automatic match_t rand_push(int unsigned decoy_pct);
		match_t m;
		m.op = OP_PUSH;
		m.dec = ($urandom_range(0, 99) < decoy_pct);
		m.dh = $urandom_range(0, 15);
		m.th = $urandom_range(0, 15);
		m.has = $urandom_range(0, 1);
		m.nv = $urandom_range(0, 7);
		return m;
	endfunction

	function automatic match_t rand_pop();
		match_t m;
		m = rand_push(50);
		m.op = OP_POP;
		return m;
	endfunction

	// The result side stalls in random bursts, and never near the end.
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= (stall_left == 1);
		end else if (arst_n && !quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n;
		end
	end

	task automatic cmp(string name, longint unsigned e, longint unsigned a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			mismatches++;
		end
	endtask

	// Each result beat is checked against the oldest expectation.
	always @(posedge clk) begin
		qres_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation waiting");
				mismatches++;
			end else begin
				e = pending_results.pop_front();
				cmp("status", e.status, status);
				cmp("is_final", e.is_final, is_final);
				cmp("group_done", e.group_done, group_done);
				cmp("target_count", e.tc, target_count);
				cmp("decoy_sum", e.ds, decoy_sum);
				cmp("q_value", e.q, q_value);
				cmp("notch_target_count", e.ntc, notch_target_count);
				cmp("notch_decoy_sum", e.nds, notch_decoy_sum);
				cmp("notch_q_value", e.nq, notch_q_value);
				cmp("notch_index", e.ni, notch_index);
			end
		end
	end

	initial begin
		#60000000;
		$display("[target_decoy_qvalue_engine] ERROR");
		$finish;
	end

	initial begin
		qres_t none;
		int unsigned grp, len, pct, v;
		none = '{default: '0};
		notch_cfg = 0;
		depth = 0;
		clear_counts();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Typed rows: empty pop after reset, a first target, full decoys,
		// clamped hits, zero total hits and an empty pop once the stack is unwound.
		add_row('{0, 0, '{OP_POP, 1, 15, 15, 1, 7}, 1,
			'{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
		add_row('{0, 0, '{OP_PUSH, 0, 0, 0, 0, 0}, 1,
			'{ST_OK, 0, 0, 1, 0, 0, 1, 0, 0, 0}});
		add_row('{0, 0, '{OP_PUSH, 1, 15, 15, 0, 0}, 1,
			'{ST_OK, 0, 0, 1, 65536, 65536, 1, 65536, 65536, 0}});
		add_row('{0, 0, '{OP_PUSH, 1, 15, 3, 1, 0}, 1,
			'{ST_OK, 0, 0, 1, 131072, 65536, 1, 131072, 65536, 0}});
		add_row('{0, 0, '{OP_PUSH, 1, 0, 0, 0, 7}, 1,
			'{ST_OK, 0, 0, 1, 196608, 65536, 1, 196608, 65536, 0}});
		add_row('{0, 0, '{OP_PUSH, 1, 0, 15, 0, 0}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 1, 1, 7, 1, 3}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 0, 15, 0, 1, 7}, 0, none});
		for (int i = 0; i < 7; i++)
			add_row('{0, 0, '{OP_POP, 1, 15, 15, 1, 7}, 0, none});
		add_row('{0, 0, '{OP_POP, 0, 0, 0, 0, 0}, 1,
			'{ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
		add_row('{1, 7, '{OP_PUSH, 0, 0, 0, 0, 0}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 0, 0, 0, 1, 7}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 1, 3, 4, 0, 0}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 1, 5, 9, 1, 2}, 0, none});
		add_row('{0, 0, '{OP_PUSH, 0, 0, 1, 1, 2}, 0, none});
		for (int i = 0; i < 4; i++)
			add_row('{0, 0, '{OP_POP, 0, 0, 0, 0, 0}, 0, none});

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg)
				write_notches(dir_tab[i].cval);
			else
				send_match(dir_tab[i].it, dir_tab[i].typed, dir_tab[i].exp);
		end

		// Random part: mostly whole groups (pushes, then pops down to empty) and
		// some mixed noise, then one run that fills the stack, pushes twice onto
		// the full stack and unwinds part of it.
		grp = 0;
		while (n_sent < 780) begin
			if (grp % 6 == 0) begin
				v = (grp == 0) ? 0 : (grp == 6) ? 7 : $urandom_range(0, 7);
				write_notches(v);
			end
			calm = ($urandom_range(0, 3) == 0);
			pct = $urandom_range(0, 100);
			if ($urandom_range(0, 9) < 7) begin
				len = $urandom_range(1, 40);
				repeat (len) send_match(rand_push(pct), 0, none);
				while (depth != 0)
					send_match(rand_pop(), 0, none);
			end else begin
				len = $urandom_range(1, 30);
				repeat (len) begin
					if ($urandom_range(0, 2) == 0)
						send_match(rand_pop(), 0, none);
					else
						send_match(rand_push(pct), 0, none);
				end
			end
			grp++;
		end
		calm = 1'b0;
		pct = $urandom_range(0, 100);
		while (depth < DEPTH) begin
			send_match(rand_push($urandom_range(0, 1) ? 30 : pct), 0, none);
			quiet = (n_sent > 1550);
		end
		repeat (2) send_match(rand_push(pct), 0, none);
		quiet = 1'b1;
		repeat (40) send_match(rand_pop(), 0, none);
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Covered %0d pushes, %0d pops, %0d groups emptied,", n_push, n_pop,
			n_groups);
		$display("%0d pushes on a full stack and %0d pops on an empty one.", n_full,
			n_empty);
		if (mismatches == 0)
			$display("[target_decoy_qvalue_engine] OK");
		else
			$display("[target_decoy_qvalue_engine] ERROR");
		$finish;
	end

endmodule
